### design/esud_pkg.sv
// shared types, constants and the month length table for the epoch to utc date block
// used by esud_ctrl, esud_datapath and epoch_seconds_to_utc_date_core; no dependencies
package esud_pkg;

  localparam int SECONDS_BITS_DEFAULT = 40;
  localparam int YEAR_W               = 15;

  localparam int SECS_PER_DAY       = 86400;
  localparam int SECS_PER_HOUR      = 3600;
  localparam int SECS_PER_MIN       = 60;
  localparam int DAYS_PER_400Y      = 146097;
  localparam int DAYS_1600_TO_1970  = 135140;
  localparam int DAYS_CENT_FIRST    = 36525;
  localparam int DAYS_CENT          = 36524;
  localparam int DAYS_QUAD          = 1461;
  localparam int DAYS_QUAD_SHORT    = 1460;
  localparam int DAYS_LEAP_YEAR     = 366;
  localparam int DAYS_YEAR          = 365;
  localparam int BASE_YEAR          = 1600;
  localparam int YEARS_PER_CYCLE    = 400;
  localparam int YEARS_PER_CENT     = 100;
  localparam int LAST_CENT          = 3;
  localparam int LAST_QUAD          = 24;
  localparam int LAST_YEAR_IN_QUAD  = 3;
  localparam int LAST_MONTH         = 11;
  localparam int HOUR_BITS          = 5;
  localparam int MINUTE_BITS        = 6;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_START,
    CMD_DIV,
    CMD_SETUP_CYC,
    CMD_SETUP_WALK,
    CMD_CENT,
    CMD_QUAD,
    CMD_YEAR,
    CMD_MONTH,
    CMD_SETUP_HOUR,
    CMD_SETUP_MIN,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic cent_take;
    logic quad_take;
    logic year_take;
    logic mon_take;
    logic out_free;
  } status_t;

  function automatic logic [4:0] month_length(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### design/epoch_seconds_to_utc_date_core.sv
// top level of the epoch seconds to utc calendar date converter
// depends on esud_pkg, esud_ctrl and esud_datapath
//
// usage:
//   input channel in_valid / in_ready carries epoch_seconds, a signed count of
//   seconds since 1970-01-01 00:00:00 utc; negative counts give the epoch itself
//   output channel out_valid / out_ready carries year, month_index (0 = january),
//   day_of_month, hour, minute and second
//   one transaction is in work at a time; in_ready is high while the unit is idle
//   steps: the accept, a restoring divide by 86400, a setup, a restoring divide
//   by 146097, a setup, a walk over centuries, four-year blocks, years and
//   months, a setup, the hour divide, a setup, the minute divide and the load
//   of the output register; all divides share one compare/subtract unit, and
//   the walk steps its century, block, year and month counters
//   the result sits in an output register, so a new transaction is taken while
//   the receiver stalls; the unit only waits before loading the next result
//   reset (synchronous, active high) returns the controller to idle and drops
//   out_valid; the other datapath registers are not reset
module epoch_seconds_to_utc_date_core import esud_pkg::*; #(
  parameter int SECONDS_BITS = SECONDS_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SECONDS_BITS-1:0] epoch_seconds,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [YEAR_W-1:0]              year,
  output logic [3:0]                     month_index,
  output logic [4:0]                     day_of_month,
  output logic [4:0]                     hour,
  output logic [5:0]                     minute,
  output logic [5:0]                     second
);

  cmd_t    cmd;
  status_t status;

  esud_ctrl #(
    .SECONDS_BITS(SECONDS_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  esud_datapath #(
    .SECONDS_BITS(SECONDS_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .epoch_seconds (epoch_seconds),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .year          (year),
    .month_index   (month_index),
    .day_of_month  (day_of_month),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

  // a loaded result is always a legal calendar time
  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month_index <= 4'd11) && (day_of_month != 5'd0) &&
                  (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59))
    else $error("result field out of range");

  // an accepted transaction leaves the unit busy in the cycle after the accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after accept");

  // a new result appears exactly as the controller returns to idle
  a_result_with_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded while controller busy");

endmodule

### design/esud_datapath.sv
// datapath: shared restoring divide step, calendar walk registers and output register
// depends on esud_pkg; driven by commands from esud_ctrl
module esud_datapath import esud_pkg::*; #(
  parameter int SECONDS_BITS = SECONDS_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cmd_t                           cmd,
  output status_t                        status,
  input  logic signed [SECONDS_BITS-1:0] epoch_seconds,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [YEAR_W-1:0]              year,
  output logic [3:0]                     month_index,
  output logic [4:0]                     day_of_month,
  output logic [4:0]                     hour,
  output logic [5:0]                     minute,
  output logic [5:0]                     second
);

  localparam int SB = SECONDS_BITS;
  localparam int QW = SB - 17;
  localparam int Q2 = (SB > 36) ? SB - 33 : 3;
  localparam logic [SB-1:0] DV_DAY  = SB'(SECS_PER_DAY) << (SB - 18);
  localparam logic [SB-1:0] DV_CYC  = SB'(DAYS_PER_400Y) << (Q2 - 1);
  localparam logic [SB-1:0] DV_HOUR = SB'(SECS_PER_HOUR) << (HOUR_BITS - 1);
  localparam logic [SB-1:0] DV_MIN  = SB'(SECS_PER_MIN) << (MINUTE_BITS - 1);

  logic [SB-1:0]     r;
  logic [SB-1:0]     dv;
  logic [QW-1:0]     q;
  logic [16:0]       tod;
  logic [17:0]       dd;
  logic [1:0]        cent;
  logic [4:0]        quad;
  logic [1:0]        yr;
  logic [3:0]        mon;
  logic [YEAR_W-1:0] ybase;
  logic [4:0]        hour_q;

  logic        ge;
  logic        leap;
  logic [17:0] cent_len;
  logic [17:0] quad_len;
  logic [17:0] year_len;
  logic [17:0] mon_len;

  always_comb begin
    ge       = (r >= dv);
    // the year opening a quad is short only in the first quad of the 2nd..4th century of a cycle
    leap     = (yr == 2'd0) && !((quad == 5'd0) && (cent != 2'd0));
    cent_len = (cent == 2'd0) ? 18'(DAYS_CENT_FIRST) : 18'(DAYS_CENT);
    quad_len = ((quad == 5'd0) && (cent != 2'd0)) ? 18'(DAYS_QUAD_SHORT) : 18'(DAYS_QUAD);
    year_len = leap ? 18'(DAYS_LEAP_YEAR) : 18'(DAYS_YEAR);
    mon_len  = 18'(month_length(mon, leap));
    status.cent_take = (cent != 2'(LAST_CENT)) && (dd >= cent_len);
    status.quad_take = (quad != 5'(LAST_QUAD)) && (dd >= quad_len);
    status.year_take = (yr != 2'(LAST_YEAR_IN_QUAD)) && (dd >= year_len);
    status.mon_take  = (mon != 4'(LAST_MONTH)) && (dd >= mon_len);
    status.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_START: begin
        // negative counts clamp to the epoch
        r  <= epoch_seconds[SB-1] ? '0 : SB'(epoch_seconds);
        dv <= DV_DAY;
        q  <= '0;
      end
      CMD_DIV: begin
        if (ge) begin
          r <= r - dv;
        end
        q  <= {q[QW-2:0], ge};
        dv <= dv >> 1;
      end
      CMD_SETUP_CYC: begin
        tod <= r[16:0];
        r   <= SB'(q) + SB'(DAYS_1600_TO_1970);
        dv  <= DV_CYC;
        q   <= '0;
      end
      CMD_SETUP_WALK: begin
        dd    <= r[17:0];
        cent  <= '0;
        quad  <= '0;
        yr    <= '0;
        mon   <= '0;
        ybase <= YEAR_W'(BASE_YEAR) + q[YEAR_W-1:0] * YEAR_W'(YEARS_PER_CYCLE);
      end
      CMD_CENT: begin
        if (status.cent_take) begin
          dd   <= dd - cent_len;
          cent <= cent + 2'd1;
        end
      end
      CMD_QUAD: begin
        if (status.quad_take) begin
          dd   <= dd - quad_len;
          quad <= quad + 5'd1;
        end
      end
      CMD_YEAR: begin
        if (status.year_take) begin
          dd <= dd - year_len;
          yr <= yr + 2'd1;
        end
      end
      CMD_MONTH: begin
        if (status.mon_take) begin
          dd  <= dd - mon_len;
          mon <= mon + 4'd1;
        end
      end
      CMD_SETUP_HOUR: begin
        r  <= SB'(tod);
        dv <= DV_HOUR;
        q  <= '0;
      end
      CMD_SETUP_MIN: begin
        hour_q <= q[4:0];
        dv     <= DV_MIN;
        q      <= '0;
      end
      CMD_FINISH: begin
        // {quad, yr} is the year offset within the century
        year         <= ybase + YEAR_W'(cent) * YEAR_W'(YEARS_PER_CENT) + YEAR_W'({quad, yr});
        month_index  <= mon;
        day_of_month <= dd[4:0] + 5'd1;
        hour         <= hour_q;
        minute       <= q[5:0];
        second       <= r[5:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### design/esud_ctrl.sv
// controller: sequences the divide steps, calendar walk and output load
// depends on esud_pkg; commands esud_datapath
module esud_ctrl import esud_pkg::*; #(
  parameter int SECONDS_BITS = SECONDS_BITS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int SB        = SECONDS_BITS;
  localparam int DAY_STEPS = SB - 17;
  localparam int Q2        = (SB > 36) ? SB - 33 : 3;
  localparam int CNT_W     = $clog2(DAY_STEPS);

  typedef enum logic [13:0] {
    S_IDLE       = 14'b00000000000001,
    S_DIV_DAY    = 14'b00000000000010,
    S_SETUP_CYC  = 14'b00000000000100,
    S_DIV_CYC    = 14'b00000000001000,
    S_SETUP_WALK = 14'b00000000010000,
    S_CENT       = 14'b00000000100000,
    S_QUAD       = 14'b00000001000000,
    S_YEAR       = 14'b00000010000000,
    S_MONTH      = 14'b00000100000000,
    S_SETUP_HOUR = 14'b00001000000000,
    S_DIV_HOUR   = 14'b00010000000000,
    S_SETUP_MIN  = 14'b00100000000000,
    S_DIV_MIN    = 14'b01000000000000,
    S_FINISH     = 14'b10000000000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_START;
          cnt_next   = CNT_W'(DAY_STEPS - 1);
          state_next = S_DIV_DAY;
        end
      end
      S_DIV_DAY: begin
        cmd = CMD_DIV;
        if (cnt == '0) state_next = S_SETUP_CYC;
        else cnt_next = cnt - 1'b1;
      end
      S_SETUP_CYC: begin
        cmd        = CMD_SETUP_CYC;
        cnt_next   = CNT_W'(Q2 - 1);
        state_next = S_DIV_CYC;
      end
      S_DIV_CYC: begin
        cmd = CMD_DIV;
        if (cnt == '0) state_next = S_SETUP_WALK;
        else cnt_next = cnt - 1'b1;
      end
      S_SETUP_WALK: begin
        cmd        = CMD_SETUP_WALK;
        state_next = S_CENT;
      end
      S_CENT: begin
        cmd = CMD_CENT;
        if (!status.cent_take) state_next = S_QUAD;
      end
      S_QUAD: begin
        cmd = CMD_QUAD;
        if (!status.quad_take) state_next = S_YEAR;
      end
      S_YEAR: begin
        cmd = CMD_YEAR;
        if (!status.year_take) state_next = S_MONTH;
      end
      S_MONTH: begin
        cmd = CMD_MONTH;
        if (!status.mon_take) state_next = S_SETUP_HOUR;
      end
      S_SETUP_HOUR: begin
        cmd        = CMD_SETUP_HOUR;
        cnt_next   = CNT_W'(HOUR_BITS - 1);
        state_next = S_DIV_HOUR;
      end
      S_DIV_HOUR: begin
        cmd = CMD_DIV;
        if (cnt == '0) state_next = S_SETUP_MIN;
        else cnt_next = cnt - 1'b1;
      end
      S_SETUP_MIN: begin
        cmd        = CMD_SETUP_MIN;
        cnt_next   = CNT_W'(MINUTE_BITS - 1);
        state_next = S_DIV_MIN;
      end
      S_DIV_MIN: begin
        cmd = CMD_DIV;
        if (cnt == '0) state_next = S_FINISH;
        else cnt_next = cnt - 1'b1;
      end
      S_FINISH: begin
        // hold the finished date until the output register is free
        if (status.out_free) begin
          cmd        = CMD_FINISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule
